FILE: rtl/core/bounded_deque_with_search_unit_assert.svh
// assertion macros for the bounded deque with search unit
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDQS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BDQS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

FILE: rtl/core/bdqs_pkg.sv
// shared constants, codes and item types of the deque unit
`timescale 1ns / 1ps

package bdqs_pkg;

	localparam int unsigned DQ_CAPACITY = 64;
	localparam int unsigned IDX_W = (DQ_CAPACITY > 1) ? $clog2(DQ_CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(DQ_CAPACITY + 1);

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;
	localparam logic [2:0] OP_CLEAR      = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
	} bdqs_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [CNT_W-1:0] occupancy;
		logic             is_empty;
	} bdqs_out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_start;
		logic scan_step;
		logic scan_end;
		logic publish;
	} bdqs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_search;
		logic cnt_zero;
		logic scan_last;
		logic out_free;
	} bdqs_sts_t;

endpackage

FILE: rtl/core/bdqs_ctrl.sv
// controller state machine of the deque unit
`timescale 1ns / 1ps

module bdqs_ctrl
	import bdqs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  bdqs_sts_t sts,
	output bdqs_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd.capture    = (state_q == S_IDLE) && in_valid;
		cmd.exec       = (state_q == S_EXEC);
		cmd.scan_start = (state_q == S_EXEC) && sts.is_search && !sts.cnt_zero;
		cmd.scan_step  = (state_q == S_SCAN) && !sts.scan_last;
		cmd.scan_end   = (state_q == S_SCAN) && sts.scan_last;
		cmd.publish    = (state_q == S_FINISH) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.is_search && !sts.cnt_zero) state_d = S_SCAN;
				else state_d = S_FINISH;
			end
			S_SCAN: begin
				if (sts.scan_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: rtl/core/bdqs_dp.sv
// datapath of the deque unit: entry memory, pointers, scan and result register
`timescale 1ns / 1ps

module bdqs_dp
	import bdqs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bdqs_in_t  in_item,
	input  bdqs_cmd_t cmd,
	output bdqs_sts_t sts,
	output logic      out_valid,
	input  logic      out_stall,
	output bdqs_out_t out_item
);

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
		if (x == IDX_W'(DQ_CAPACITY - 1)) return '0;
		return x + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
		if (x == '0) return IDX_W'(DQ_CAPACITY - 1);
		return x - 1'b1;
	endfunction

	logic signed [31:0] mem [DQ_CAPACITY];

	logic [2:0]         op_q;
	logic signed [31:0] value_q;
	logic [IDX_W-1:0]   front_q, front_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [1:0]         status_q, status_d;
	logic               found_q;
	logic               hit_q;
	logic [CNT_W-1:0]   k_q;
	logic [IDX_W-1:0]   rd_addr_q, rd_addr;
	logic signed [31:0] rd_data_q;
	logic               out_valid_q;
	bdqs_out_t          out_q;

	logic               full, empty, match, rd_en, wr_en, mem_we;
	logic [IDX_W-1:0]   wr_addr, back_slot;
	logic [CNT_W:0]     back_sum;

	assign full  = (count_q == CNT_W'(DQ_CAPACITY));
	assign empty = (count_q == '0);
	assign match = (rd_data_q == value_q);

	// slot one past the back entry, wrapped
	assign back_sum  = {1'b0, CNT_W'(front_q)} + {1'b0, count_q};
	assign back_slot = (back_sum >= (CNT_W + 1)'(DQ_CAPACITY))
		? IDX_W'(back_sum - (CNT_W + 1)'(DQ_CAPACITY)) : IDX_W'(back_sum);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = back_slot;
		front_d  = front_q;
		count_d  = count_q;
		status_d = ST_OK;
		unique case (op_q)
			OP_PUSH_FRONT: begin
				if (full) status_d = ST_FULL;
				else begin
					front_d = idx_dec(front_q);
					wr_addr = idx_dec(front_q);
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) status_d = ST_FULL;
				else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) status_d = ST_EMPTY;
				else begin
					front_d = idx_inc(front_q);
					count_d = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) status_d = ST_EMPTY;
				else count_d = count_q - 1'b1;
			end
			OP_CLEAR: begin
				front_d = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign mem_we  = cmd.exec && wr_en;
	assign rd_en   = cmd.scan_start || cmd.scan_step;
	assign rd_addr = cmd.scan_start ? front_q : idx_inc(rd_addr_q);

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= value_q;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_item.operation;
			value_q <= in_item.value;
		end
		if (rd_en) rd_addr_q <= rd_addr;
		if (cmd.exec) status_q <= status_d;
		if (cmd.scan_start) hit_q <= 1'b0;
		else if (cmd.scan_step) hit_q <= hit_q | match;
		if (cmd.scan_end) found_q <= hit_q | match;
		else if (cmd.exec) found_q <= 1'b0;
		if (cmd.publish) begin
			out_q.status    <= status_q;
			out_q.found     <= found_q;
			out_q.occupancy <= count_q;
			out_q.is_empty  <= empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				front_q <= front_d;
				count_q <= count_d;
			end
			if (cmd.scan_start) k_q <= CNT_W'(1);
			else if (cmd.scan_step) k_q <= k_q + 1'b1;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.is_search = (op_q == OP_SEARCH);
		sts.cnt_zero  = empty;
		sts.scan_last = (k_q == count_q);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: rtl/core/bounded_deque_with_search_unit.sv
// top level of the bounded deque with search: handshake ports, controller and datapath
// push, pop, clear and unused codes: execute and finish states, then the output register
// a non-empty search also passes the scan state: one read per cycle of the entry memory
// one item in work at a time: a new item is taken only in the idle state
// reset clears front index, count, scan counter, controller state and output valid
// the entry memory is not cleared: only stored entries are ever read
`timescale 1ns / 1ps
`include "bounded_deque_with_search_unit_assert.svh"

module bounded_deque_with_search_unit
	import bdqs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  bdqs_in_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output bdqs_out_t out_item
);

	// command and status groups between controller and datapath
	bdqs_cmd_t cmd;
	bdqs_sts_t sts;

	// controller: idle, execute, scan, finish
	// execute applies the push/pop/clear update;
	// a search walks the stored entries from the front, one read per cycle
	bdqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: circular entry memory with front index and count,
	// registered read and compare for the scan, output register for the result item
	bdqs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// occupancy never goes past the capacity
	`BDQS_ASSERT_NOW(a_occ_bound, out_valid, out_item.occupancy <= CNT_W'(DQ_CAPACITY))

	// empty flag agrees with occupancy
	`BDQS_ASSERT_NOW(a_empty_flag, out_valid, out_item.is_empty == (out_item.occupancy == '0))

	// a hit is only reported with ok status
	`BDQS_ASSERT_NOW(a_found_ok, out_valid && out_item.found, out_item.status == ST_OK)

	// an accepted item keeps the input side stalled while it is worked on
	`BDQS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule
